// ===== hw/rtl/ssp_pkg.sv =====
// ============================================================================
// ssp_pkg - shared segment pair finder package
// Types and codes shared by the front end, the command queue, the back end
// and the top level.
// ============================================================================
package ssp_pkg;

  localparam int unsigned GROUP_DEPTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned IN_TDATA_W  = 128;
  localparam int unsigned OUT_TDATA_W = 144;

  // Kind of work the front end hands to the back end.
  typedef enum logic [1:0] {
    CMD_PAIRS    = 2'd0,
    CMD_SORT_ERR = 2'd1,
    CMD_FULL_ERR = 2'd2
  } cmd_kind_e;

  // Result status codes, carried on the output tuser.
  typedef enum logic [1:0] {
    ST_PAIR = 2'd0,
    ST_SORT = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  chr;
    logic        hap;
    logic [31:0] seg_start;
    logic [31:0] seg_end;
  } segment_t;

  typedef struct packed {
    cmd_kind_e kind;
    segment_t  seg;
  } cmd_t;

  typedef struct packed {
    logic [15:0] first_individual;
    logic [15:0] second_individual;
    logic [7:0]  pair_chromosome;
    logic [31:0] overlap_start;
    logic [31:0] overlap_end;
    logic [32:0] overlap_length;
    logic        first_hap;
    logic        second_hap;
    logic        last_of_run;
    status_e     status;
  } result_t;

endpackage

// ===== hw/rtl/shared_segment_pair_finder.sv =====
// ============================================================================
// shared_segment_pair_finder - pairs of overlapping segments within a group
// Buffers the segments of the current group and reports every earlier
// segment of a larger id whose interval overlaps a newly arrived one.
// ============================================================================
//
// Channel   Dir  Handshake                       Contents
// s_axis    in   s_axis_tvalid / s_axis_tready   one segment per item
// m_axis    out  m_axis_tvalid / m_axis_tready   one pair or error per item
//
// Flow: an item whose group holds N earlier segments is taken from the queue,
// then the group buffer is scanned through its single read port one entry per
// cycle while a busy output does not hold the scan, and the last pair is
// released at the end. The first segment of a group is only taken and stored,
// and an out-of-order or overflow item is turned into an error result.
// Reset: rst_ni clears the group state, the command queue and all valid
// flags; the buffer contents need no clearing because only filled entries
// are read.
// Stalls: the front end keeps accepting items until the two-entry command
// queue is full; a busy output freezes the scan pipeline when a new hit waits.
//
module shared_segment_pair_finder #(
  parameter int unsigned GROUP_DEPTH = ssp_pkg::GROUP_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // individual_id [15:0], chromosome [23:16], haplotype [24],
  // segment_start [56:25], segment_end [88:57], group_index [120:89]
  input  logic [ssp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // first_individual [15:0], second_individual [31:16],
  // pair_chromosome [39:32], overlap_start [71:40], overlap_end [103:72],
  // overlap_length [136:104], first_hap [137], second_hap [138]
  output logic [ssp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,
  // status [1:0]
  output logic [1:0]                      m_axis_tuser
);

  localparam int unsigned CntW    = $clog2(GROUP_DEPTH + 1);
  localparam int unsigned CmdBits = $bits(ssp_pkg::cmd_t);
  localparam int unsigned QW      = CmdBits + CntW;

  ssp_pkg::segment_t in_seg;
  logic [31:0]       in_group;

  logic              q_full, q_push, q_pop, q_valid;
  ssp_pkg::cmd_t     f_cmd, b_cmd;
  logic [CntW-1:0]   f_cnt, b_cnt;
  logic [QW-1:0]     q_wdata, q_rdata;
  ssp_pkg::result_t  res;

  // Unpack the input item.
  assign in_seg.id        = s_axis_tdata[15:0];
  assign in_seg.chr       = s_axis_tdata[23:16];
  assign in_seg.hap       = s_axis_tdata[24];
  assign in_seg.seg_start = s_axis_tdata[56:25];
  assign in_seg.seg_end   = s_axis_tdata[88:57];
  assign in_group         = s_axis_tdata[120:89];

  ssp_front #(
    .GroupDepth (GROUP_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_seg_i   (in_seg),
    .in_group_i (in_group),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (f_cmd),
    .q_cnt_o    (f_cnt)
  );

  // The command carries the number of buffered entries to scan, which is
  // also the buffer slot the new segment is written to.
  assign q_wdata = {f_cnt, f_cmd};
  assign b_cmd   = ssp_pkg::cmd_t'(q_rdata[CmdBits-1:0]);
  assign b_cnt   = q_rdata[QW-1:CmdBits];

  ssp_fifo #(
    .Width (QW),
    .Depth (ssp_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  ssp_back #(
    .GroupDepth (GROUP_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (b_cmd),
    .cmd_cnt_i   (b_cnt),
    .cmd_pop_o   (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result item.
  assign m_axis_tdata = {5'd0,
                         res.second_hap,
                         res.first_hap,
                         res.overlap_length,
                         res.overlap_end,
                         res.overlap_start,
                         res.pair_chromosome,
                         res.second_individual,
                         res.first_individual};
  assign m_axis_tlast = res.last_of_run;
  assign m_axis_tuser = res.status;

`ifndef NO_ASSERTIONS
  // The front end must never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("command pushed into a full queue");

  // Error results close their run and name no earlier segment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ssp_pkg::ST_PAIR) |->
      (m_axis_tlast && res.first_individual == '0 && res.overlap_length == '0))
    else $error("malformed error result");

  // A pair result always describes a real overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ssp_pkg::ST_PAIR) |->
      (res.overlap_start <= res.overlap_end &&
       res.first_individual > res.second_individual))
    else $error("pair result without overlap or id order");

  // A queued command is only taken when one is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("command popped from an empty queue");
`endif

endmodule

// ===== hw/rtl/ssp_front.sv =====
// ============================================================================
// ssp_front - input classification
// Tracks the open group and its fill level, and turns every accepted item
// into a command for the back end.
// ============================================================================
module ssp_front #(
  parameter int unsigned GroupDepth = ssp_pkg::GROUP_DEPTH_DEF,
  localparam int unsigned CntW      = $clog2(GroupDepth + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssp_pkg::segment_t in_seg_i,
  input  logic [31:0]       in_group_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output ssp_pkg::cmd_t     q_cmd_o,
  output logic [CntW-1:0]   q_cnt_o
);

  logic            open_q, open_d;
  logic [31:0]     group_q, group_d;
  logic [CntW-1:0] count_q, count_d;
  logic            accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    open_d      = open_q;
    group_d     = group_q;
    count_d     = count_q;
    q_cmd_o.seg = in_seg_i;
    q_cmd_o.kind = ssp_pkg::CMD_PAIRS;
    q_cnt_o     = count_q;
    priority if (!open_q || in_group_i > group_q) begin
      // A new group starts with an empty buffer.
      q_cnt_o = '0;
      if (accept) begin
        open_d  = 1'b1;
        group_d = in_group_i;
        count_d = CntW'(1);
      end
    end else if (in_group_i < group_q) begin
      q_cmd_o.kind = ssp_pkg::CMD_SORT_ERR;
    end else if (count_q >= CntW'(GroupDepth)) begin
      q_cmd_o.kind = ssp_pkg::CMD_FULL_ERR;
    end else begin
      if (accept) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      group_q <= '0;
      count_q <= '0;
    end else begin
      open_q  <= open_d;
      group_q <= group_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== hw/rtl/ssp_fifo.sv =====
// ============================================================================
// ssp_fifo - command queue
// Short register queue between the front end and the back end.
// ============================================================================
module ssp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = ssp_pkg::QUEUE_DEPTH,
  localparam int unsigned PtrW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign data_o  = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ssp_back.sv =====
// ============================================================================
// ssp_back - group buffer and pair scan
// Stores the segments of the open group and compares each new segment with
// the stored ones, one entry per cycle, through a short stall-able pipeline.
// ============================================================================
module ssp_back #(
  parameter int unsigned GroupDepth = ssp_pkg::GROUP_DEPTH_DEF,
  localparam int unsigned CntW      = $clog2(GroupDepth + 1),
  localparam int unsigned IdxW      = $clog2(GroupDepth)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  ssp_pkg::cmd_t     cmd_i,
  input  logic [CntW-1:0]   cmd_cnt_i,
  output logic              cmd_pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output ssp_pkg::result_t  res_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;

  ssp_pkg::segment_t mem [GroupDepth];
  ssp_pkg::segment_t cur_q, rd_q;
  logic [CntW-1:0]   cnt_q, idx_q;

  logic        v1_q, last1_q;
  logic        v2_q, last2_q, hit2_q;
  logic [15:0] id2_q;
  logic [7:0]  chr2_q;
  logic        hap2_q;
  logic [31:0] os2_q, oe2_q;

  logic             pend_v_q;
  ssp_pkg::result_t pend_q, cand;
  logic             out_v_q;
  ssp_pkg::result_t out_q;

  logic             can_push, push_en, adv, issue, mem_we, rd_en;
  ssp_pkg::result_t push_res;
  logic [31:0]      os1, oe1;
  logic             hit1;

  assign can_push    = !out_v_q || res_ready_i;
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;
  assign issue       = idx_q != cnt_q;

  // Stage one: overlap bounds against the new segment.
  always_comb begin
    os1  = (rd_q.seg_start > cur_q.seg_start) ? rd_q.seg_start : cur_q.seg_start;
    oe1  = (rd_q.seg_end < cur_q.seg_end) ? rd_q.seg_end : cur_q.seg_end;
    hit1 = (rd_q.id > cur_q.id) && (os1 <= oe1);
  end

  // Stage two: the full pair result.
  always_comb begin
    cand.first_individual  = id2_q;
    cand.second_individual = cur_q.id;
    cand.pair_chromosome   = chr2_q;
    cand.overlap_start     = os2_q;
    cand.overlap_end       = oe2_q;
    cand.overlap_length    = {1'b0, oe2_q} - {1'b0, os2_q} + 33'd1;
    cand.first_hap         = hap2_q;
    cand.second_hap        = cur_q.hap;
    cand.last_of_run       = 1'b0;
    cand.status            = ssp_pkg::ST_PAIR;
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    push_en   = 1'b0;
    push_res  = pend_q;
    adv       = 1'b1;
    mem_we    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            ssp_pkg::CMD_PAIRS: begin
              cmd_pop_o = 1'b1;
              mem_we    = 1'b1;
              if (cmd_cnt_i != '0) begin
                state_d = S_SCAN;
              end
            end
            ssp_pkg::CMD_SORT_ERR, ssp_pkg::CMD_FULL_ERR: begin
              if (can_push) begin
                cmd_pop_o = 1'b1;
                push_en   = 1'b1;
                push_res.first_individual  = '0;
                push_res.second_individual = cmd_i.seg.id;
                push_res.pair_chromosome   = cmd_i.seg.chr;
                push_res.overlap_start     = cmd_i.seg.seg_start;
                push_res.overlap_end       = cmd_i.seg.seg_end;
                push_res.overlap_length    = '0;
                push_res.first_hap         = 1'b0;
                push_res.second_hap        = cmd_i.seg.hap;
                push_res.last_of_run       = 1'b1;
                push_res.status = (cmd_i.kind == ssp_pkg::CMD_SORT_ERR) ?
                                  ssp_pkg::ST_SORT : ssp_pkg::ST_FULL;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // A new hit releases the held one; it waits if the output is busy.
        if (v2_q && hit2_q && pend_v_q) begin
          if (can_push) begin
            push_en = 1'b1;
          end else begin
            adv = 1'b0;
          end
        end
        if (adv && v2_q && last2_q) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (pend_v_q) begin
          if (can_push) begin
            push_en              = 1'b1;
            push_res.last_of_run = 1'b1;
            state_d              = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rd_en = (state_q == S_SCAN) && adv && issue;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_cnt_i[IdxW-1:0]] <= cmd_i.seg;
    end
    if (rd_en) begin
      rd_q <= mem[idx_q[IdxW-1:0]];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_pop_o) begin
      cur_q <= cmd_i.seg;
      cnt_q <= cmd_i.kind == ssp_pkg::CMD_PAIRS ? cmd_cnt_i : '0;
    end
    if (state_q == S_SCAN && adv) begin
      last1_q <= issue && (idx_q == cnt_q - CntW'(1));
      last2_q <= last1_q;
      hit2_q  <= hit1;
      id2_q   <= rd_q.id;
      chr2_q  <= rd_q.chr;
      hap2_q  <= rd_q.hap;
      os2_q   <= os1;
      oe2_q   <= oe1;
      if (v2_q && hit2_q) begin
        pend_q <= cand;
      end
    end
    if (push_en) begin
      out_q <= push_res;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) begin
        idx_q <= '0;
        v1_q  <= 1'b0;
        v2_q  <= 1'b0;
      end else if (state_q == S_SCAN && adv) begin
        if (issue) begin
          idx_q <= idx_q + CntW'(1);
        end
        v1_q <= issue;
        v2_q <= v1_q;
        if (v2_q && hit2_q) begin
          pend_v_q <= 1'b1;
        end
      end else if (state_q == S_FLUSH && push_en) begin
        pend_v_q <= 1'b0;
      end
      if (push_en) begin
        out_v_q <= 1'b1;
      end else if (res_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

endmodule
